// ----- design/spiral_reversal_permutation_assert.svh -----
// Assertion macros used by the spiral reversal permutation RTL.
`ifndef SPIRAL_REVERSAL_PERMUTATION_ASSERT_SVH
`define SPIRAL_REVERSAL_PERMUTATION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/srp_pkg.sv -----
// Package with shared types and constants of the spiral reversal permutation.
`timescale 1ns / 1ps
`default_nettype none
package srp_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int POS_W      = 12;
  localparam int STATUS_W   = 2;

  localparam logic CMD_BUILD  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNBUILT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 7'd4;
  localparam logic [CFG_DATA_W-1:0] COLS_RESET = 7'd3;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef struct packed {
    logic active;
    logic last;
  } srp_walk_stat_t;

endpackage
`default_nettype wire

// ----- design/srp_in_if.sv -----
// Input channel interface carrying command and position.
`timescale 1ns / 1ps
`default_nettype none
interface srp_in_if
  import srp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             command;
  logic [POS_W-1:0] position;

  modport source (output valid, output command, output position, input ready);
  modport sink (input valid, input command, input position, output ready);
endinterface
`default_nettype wire

// ----- design/srp_out_if.sv -----
// Output channel interface carrying source index and status.
`timescale 1ns / 1ps
`default_nettype none
interface srp_out_if
  import srp_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    source_index;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output source_index, output status, input ready);
  modport sink (input valid, input source_index, input status, output ready);
endinterface
`default_nettype wire

// ----- design/srp_walk.sv -----
// Spiral walker that produces one grid cell and its rank per cycle.
`timescale 1ns / 1ps
`default_nettype none
module srp_walk
  import srp_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [$clog2(MAX_SIDE+1)-1:0] rows,
  input  logic [$clog2(MAX_SIDE+1)-1:0] cols,
  output srp_walk_stat_t stat,
  output logic [((MAX_SIDE*MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1)-1:0] grid_cell,
  output logic [((MAX_SIDE*MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1)-1:0] step_idx,
  output logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0] total
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_INIT = 2'd1;
  localparam logic [1:0] W_RUN  = 2'd2;

  logic [1:0]        phase;
  logic [1:0]        dir;
  logic [SIDE_W-1:0] r, c, top, bottom, left, right, cols_q;
  logic [CNT_W-1:0]  step, step_inc;
  logic [ADDR_W-1:0] cols_a;

  assign step_inc = step + 1'b1;
  assign cols_a   = ADDR_W'(cols_q);
  assign step_idx = step[ADDR_W-1:0];

  always_comb begin
    stat.active = (phase == W_RUN);
    stat.last   = (phase == W_RUN) && (step_inc == total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= W_IDLE;
    end else begin
      case (phase)
        W_IDLE: begin
          if (start) phase <= W_INIT;
        end
        W_INIT: phase <= W_RUN;
        W_RUN: begin
          if (stat.last) phase <= W_IDLE;
        end
        default: phase <= W_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      W_IDLE: begin
        if (start) begin
          total  <= CNT_W'(rows) * CNT_W'(cols);
          cols_q <= cols;
          top    <= '0;
          left   <= '0;
          bottom <= rows - 1'b1;
          right  <= cols - 1'b1;
          r      <= rows - 1'b1;
          c      <= '0;
          dir    <= DIR_RIGHT;
          step   <= '0;
        end
      end
      W_INIT: begin
        grid_cell <= ADDR_W'(total - CNT_W'(cols_q));
      end
      W_RUN: begin
        step <= step_inc;
        case (dir)
          DIR_RIGHT: begin
            if (c == right) begin
              bottom    <= bottom - 1'b1;
              dir       <= DIR_UP;
              r         <= r - 1'b1;
              grid_cell <= grid_cell - cols_a;
            end else begin
              c         <= c + 1'b1;
              grid_cell <= grid_cell + 1'b1;
            end
          end
          DIR_UP: begin
            if (r == top) begin
              right     <= right - 1'b1;
              dir       <= DIR_LEFT;
              c         <= c - 1'b1;
              grid_cell <= grid_cell - 1'b1;
            end else begin
              r         <= r - 1'b1;
              grid_cell <= grid_cell - cols_a;
            end
          end
          DIR_LEFT: begin
            if (c == left) begin
              top       <= top + 1'b1;
              dir       <= DIR_DOWN;
              r         <= r + 1'b1;
              grid_cell <= grid_cell + cols_a;
            end else begin
              c         <= c - 1'b1;
              grid_cell <= grid_cell - 1'b1;
            end
          end
          default: begin
            if (r == bottom) begin
              left      <= left + 1'b1;
              dir       <= DIR_RIGHT;
              c         <= c + 1'b1;
              grid_cell <= grid_cell + 1'b1;
            end else begin
              r         <= r + 1'b1;
              grid_cell <= grid_cell + cols_a;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/spiral_reversal_permutation.sv -----
// A build item gives its result after the walker has visited every cell (sizes clamped to
// 1..MAX_SIDE); the walker writes one cell per cycle into both tables. A lookup item reads
// two dependent registered memories in turn (rank, then cell), or skips both reads when
// the table is not built or the position is out of range. One item is in work at a time; the
// next one can be accepted in the same cycle as the result becomes valid. Reset clears the
// control state and the built flag and restores a 4 by 3 grid size; tables are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "spiral_reversal_permutation_assert.svh"
module spiral_reversal_permutation
  import srp_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  srp_in_if.sink                in_ch,
  srp_out_if.source             out_ch
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BUILD = 3'd1;
  localparam logic [2:0] S_LOOK1 = 3'd2;
  localparam logic [2:0] S_LOOK2 = 3'd3;
  localparam logic [2:0] S_LOOK3 = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]            state;
  logic [CFG_DATA_W-1:0] rows_reg, cols_reg;
  logic [SIDE_W-1:0]     rows_side, cols_side;
  logic                  table_built, cfg_clear, accept, start;
  logic [CNT_W-1:0]      built_count, mirror;
  logic [POS_W-1:0]      pos_q, res_src, out_src;
  logic [STATUS_W-1:0]   res_status, out_status;
  logic                  out_valid;
  logic [ADDR_W-1:0]     pos_idx, mirror_idx, rank_q, cell_q;

  srp_walk_stat_t        w_stat;
  logic [ADDR_W-1:0]     w_cell, w_step;
  logic [CNT_W-1:0]      w_total;

  logic [ADDR_W-1:0]     spiral_mem [DEPTH];
  logic [ADDR_W-1:0]     rank_mem [DEPTH];

  always_comb begin
    if (rows_reg == '0) begin
      rows_side = SIDE_W'(1);
    end else if (32'(rows_reg) > MAX_SIDE) begin
      rows_side = SIDE_W'(MAX_SIDE);
    end else begin
      rows_side = SIDE_W'(rows_reg);
    end
    if (cols_reg == '0) begin
      cols_side = SIDE_W'(1);
    end else if (32'(cols_reg) > MAX_SIDE) begin
      cols_side = SIDE_W'(MAX_SIDE);
    end else begin
      cols_side = SIDE_W'(cols_reg);
    end
  end

  assign cfg_clear  = cfg_we && ((cfg_index == CFG_ROWS) || (cfg_index == CFG_COLS));
  assign accept     = in_ch.valid && in_ch.ready;
  assign start      = accept && (in_ch.command == CMD_BUILD);
  assign pos_idx    = ADDR_W'(pos_q);
  assign mirror     = built_count - CNT_W'(1) - CNT_W'(rank_q);
  assign mirror_idx = mirror[ADDR_W-1:0];

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.source_index = out_src;
  assign out_ch.status       = out_status;

  srp_walk #(
    .MAX_SIDE(MAX_SIDE)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .rows      (rows_side),
    .cols      (cols_side),
    .stat      (w_stat),
    .grid_cell (w_cell),
    .step_idx  (w_step),
    .total     (w_total)
  );

  always_ff @(posedge clk) begin
    if (w_stat.active) rank_mem[w_cell] <= w_step;
    rank_q <= rank_mem[pos_idx];
  end

  always_ff @(posedge clk) begin
    if (w_stat.active) spiral_mem[w_step] <= w_cell;
    cell_q <= spiral_mem[mirror_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg    <= ROWS_RESET;
      cols_reg    <= COLS_RESET;
      table_built <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_ROWS)) rows_reg <= cfg_wdata;
      if (cfg_we && (cfg_index == CFG_COLS)) cols_reg <= cfg_wdata;
      if (cfg_clear) begin
        table_built <= 1'b0;
      end else if (w_stat.active && w_stat.last) begin
        table_built <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (w_stat.active && w_stat.last) built_count <= w_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && (state != S_OUT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_BUILD;
          end else if (accept && (in_ch.command == CMD_LOOKUP)) begin
            pos_q <= in_ch.position;
            state <= S_LOOK1;
          end
        end
        S_BUILD: begin
          if (w_stat.last) begin
            res_src    <= '0;
            res_status <= ST_OK;
            state      <= S_OUT;
          end
        end
        S_LOOK1: begin
          res_src <= '0;
          if (!table_built) begin
            res_status <= ST_UNBUILT;
            state      <= S_OUT;
          end else if ((32'(pos_q) >= 32'(built_count)) || (32'(pos_q) >= DEPTH)) begin
            res_status <= ST_RANGE;
            state      <= S_OUT;
          end else begin
            state <= S_LOOK2;
          end
        end
        S_LOOK2: state <= S_LOOK3;
        S_LOOK3: begin
          res_src    <= POS_W'(cell_q);
          res_status <= ST_OK;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_src    <= res_src;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SRP_ASSERT_IMPLY(a_walk_in_build, w_stat.active, state == S_BUILD, "walker runs outside a build")
  `SRP_ASSERT_NEXT(a_built_after_walk, w_stat.active && w_stat.last && !cfg_clear, table_built, "table not marked built after the walk")
  `SRP_ASSERT_NEXT(a_cfg_clears_built, cfg_clear, !table_built, "size write did not clear the built flag")
  `SRP_ASSERT_IMPLY(a_read_only_built, state == S_LOOK2, $past(table_built), "table read started without a built table")

endmodule
`default_nettype wire
